### hw/rtl/isotp_rx_pkg.sv
package isotp_rx_pkg;

  // func codes of an incoming request
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_FRAME = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_FC   = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_EMPTY    = 3'd1;
  localparam logic [2:0] ERR_SF_LEN   = 3'd2;
  localparam logic [2:0] ERR_PCI      = 3'd3;
  localparam logic [2:0] ERR_FF       = 3'd4;
  localparam logic [2:0] ERR_SEQ      = 3'd5;
  localparam logic [2:0] ERR_TIMEOUT  = 3'd6;

  // reception phase
  localparam logic [1:0] PHASE_IDLE   = 2'd0;
  localparam logic [1:0] PHASE_FIRST  = 2'd1;
  localparam logic [1:0] PHASE_CONSEC = 2'd2;

  // pci nibbles
  localparam logic [3:0] PCI_SF = 4'h0;
  localparam logic [3:0] PCI_FF = 4'h1;
  localparam logic [3:0] PCI_CF = 4'h2;

  // configuration register indexes
  localparam logic [1:0] REG_RX_ID   = 2'd0;
  localparam logic [1:0] REG_TX_ID   = 2'd1;
  localparam logic [1:0] REG_EXT_IDS = 2'd2;
  localparam logic [1:0] REG_TIMEOUT = 2'd3;

  localparam int unsigned ID_W = 29;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  typedef struct packed {
    logic [1:0]       func;
    logic [ID_W-1:0]  id;
    logic             ext;
    logic [3:0]       len;
    logic [7:0][7:0]  bytes;
  } item_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [3:0]  seq;
    logic [11:0] total;
    logic [11:0] rcvd;
    logic [15:0] elapsed;
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0] rx_id;
    logic [ID_W-1:0] tx_id;
    logic            ext;
    logic [15:0]     timeout;
  } cfg_t;

  // results of one request still to be sent
  typedef struct packed {
    logic            fc;
    logic            fail;
    logic [2:0]      err;
    logic [2:0]      nbytes;
    logic [11:0]     pdu;
    logic            last_end;
    logic [6:0][7:0] data;
  } batch_t;

endpackage

### hw/rtl/isotp_rx_decode.sv
module isotp_rx_decode import isotp_rx_pkg::*; (
  input  item_t  item,
  input  state_t st,
  input  cfg_t   cfg,
  output state_t st_next,
  output batch_t bat,
  output logic   has_res
);

  logic [3:0]  flen_c;
  logic [3:0]  pci;
  logic [3:0]  low;
  logic [15:0] el_inc;
  logic [11:0] ff_tot;
  logic [2:0]  take_ff;
  logic [11:0] remain;
  logic [2:0]  take_cf;
  logic [11:0] rcvd_cf;
  logic        id_ok;
  logic        fail;
  logic [2:0]  err;

  assign flen_c  = (item.len > 4'd8) ? 4'd8 : item.len;
  assign pci     = item.bytes[0][7:4];
  assign low     = item.bytes[0][3:0];
  assign el_inc  = (st.elapsed != 16'hFFFF) ? st.elapsed + 16'd1 : st.elapsed;
  assign ff_tot  = {low, item.bytes[1]};
  assign take_ff = (ff_tot < 12'd6) ? ff_tot[2:0] : 3'd6;
  assign remain  = st.total - st.rcvd;
  assign take_cf = (remain < 12'd7) ? remain[2:0] : 3'd7;
  assign rcvd_cf = st.rcvd + {9'd0, take_cf};
  assign id_ok   = (item.id == cfg.rx_id) && (item.ext == cfg.ext);

  always_comb begin
    st_next = st;
    bat     = '0;
    bat.pdu = st.total;
    has_res = 1'b0;
    fail    = 1'b0;
    err     = ERR_NONE;
    unique case (item.func)
      FUNC_START: begin
        st_next.phase   = PHASE_FIRST;
        st_next.seq     = 4'd1;
        st_next.total   = 12'd0;
        st_next.rcvd    = 12'd0;
        st_next.elapsed = 16'd0;
      end
      FUNC_TICK: begin
        if (st.phase != PHASE_IDLE) begin
          st_next.elapsed = el_inc;
          if (el_inc >= cfg.timeout) begin
            fail = 1'b1;
            err  = ERR_TIMEOUT;
          end
        end
      end
      FUNC_FRAME: begin
        if (st.phase != PHASE_IDLE && id_ok) begin
          if (flen_c == 4'd0) begin
            fail = 1'b1;
            err  = ERR_EMPTY;
          end else begin
            unique case (st.phase)
              PHASE_FIRST: begin
                if (pci == PCI_SF) begin
                  if (low == 4'd0 || low[3]) begin
                    fail = 1'b1;
                    err  = ERR_SF_LEN;
                  end else if (flen_c < 4'd1 + low) begin
                    fail = 1'b1;
                    err  = ERR_TIMEOUT;
                  end else begin
                    has_res         = 1'b1;
                    bat.nbytes      = low[2:0];
                    bat.pdu         = {8'd0, low};
                    bat.last_end    = 1'b1;
                    bat.data        = item.bytes[7:1];
                    st_next.total   = {8'd0, low};
                    st_next.rcvd    = {8'd0, low};
                    st_next.phase   = PHASE_IDLE;
                  end
                end else if (pci == PCI_FF) begin
                  if (ff_tot == 12'd0 || flen_c < 4'd8) begin
                    fail = 1'b1;
                    err  = ERR_FF;
                  end else begin
                    has_res         = 1'b1;
                    bat.fc          = 1'b1;
                    bat.nbytes      = take_ff;
                    bat.pdu         = ff_tot;
                    bat.last_end    = ({9'd0, take_ff} == ff_tot);
                    bat.data        = {8'd0, item.bytes[7:2]};
                    st_next.total   = ff_tot;
                    st_next.rcvd    = {9'd0, take_ff};
                    st_next.seq     = 4'd1;
                    st_next.elapsed = 16'd0;
                    st_next.phase   = ({9'd0, take_ff} == ff_tot) ? PHASE_IDLE : PHASE_CONSEC;
                  end
                end else begin
                  fail = 1'b1;
                  err  = ERR_PCI;
                end
              end
              PHASE_CONSEC: begin
                if (pci != PCI_CF) begin
                  fail = 1'b1;
                  err  = ERR_PCI;
                end else if (low != st.seq) begin
                  fail = 1'b1;
                  err  = ERR_SEQ;
                end else if (flen_c < 4'd1 + {1'b0, take_cf}) begin
                  fail = 1'b1;
                  err  = ERR_TIMEOUT;
                end else begin
                  has_res       = 1'b1;
                  bat.nbytes    = take_cf;
                  bat.last_end  = (rcvd_cf >= st.total);
                  bat.data      = item.bytes[7:1];
                  st_next.rcvd  = rcvd_cf;
                  st_next.seq   = st.seq + 4'd1;
                  st_next.phase = (rcvd_cf >= st.total) ? PHASE_IDLE : PHASE_CONSEC;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      default: begin
      end
    endcase
    if (fail) begin
      has_res       = 1'b1;
      bat.fail      = 1'b1;
      bat.err       = err;
      st_next.phase = PHASE_IDLE;
    end
  end

endmodule

### hw/rtl/isotp_rx_emit.sv
module isotp_rx_emit import isotp_rx_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  batch_t          bat_in,
  input  logic [ID_W-1:0] tx_id,
  input  logic            tx_ext,
  input  logic            out_stall,
  output logic            free,
  output logic            out_valid,
  output logic [1:0]      kind,
  output logic [7:0]      data_byte,
  output logic [11:0]     pdu_length,
  output logic [2:0]      error_code,
  output logic [ID_W-1:0] out_id,
  output logic            out_ext,
  output logic            last
);

  batch_t bat;
  logic   busy;
  logic   rem_one;
  logic   out_ready;
  logic   fire;

  assign busy      = bat.fc || bat.fail || (bat.nbytes != 3'd0);
  assign rem_one   = (bat.fc && !bat.fail && bat.nbytes == 3'd0)
                  || (!bat.fc && bat.fail && bat.nbytes == 3'd0)
                  || (!bat.fc && !bat.fail && bat.nbytes == 3'd1);
  assign out_ready = !out_valid || !out_stall;
  assign fire      = busy && out_ready;
  assign free      = !busy || (fire && rem_one);

  always_ff @(posedge clk) begin
    if (load) begin
      bat <= bat_in;
    end else if (fire) begin
      // flow control goes first, then a failure, then the payload bytes in order
      priority if (bat.fc) begin
        bat.fc <= 1'b0;
      end else if (bat.fail) begin
        bat.fail <= 1'b0;
      end else begin
        bat.data   <= {8'd0, bat.data[6:1]};
        bat.nbytes <= bat.nbytes - 3'd1;
      end
    end
    if (rst) begin
      bat.fc     <= 1'b0;
      bat.fail   <= 1'b0;
      bat.nbytes <= 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      out_valid <= fire;
    end
    if (fire) begin
      priority if (bat.fc) begin
        kind       <= KIND_FC;
        data_byte  <= 8'd0;
        error_code <= ERR_NONE;
        out_id     <= tx_id;
        out_ext    <= tx_ext;
        last       <= 1'b0;
      end else if (bat.fail) begin
        kind       <= KIND_FAIL;
        data_byte  <= 8'd0;
        error_code <= bat.err;
        out_id     <= '0;
        out_ext    <= 1'b0;
        last       <= 1'b1;
      end else begin
        kind       <= KIND_BYTE;
        data_byte  <= bat.data[0];
        error_code <= ERR_NONE;
        out_id     <= '0;
        out_ext    <= 1'b0;
        last       <= bat.last_end && (bat.nbytes == 3'd1);
      end
      pdu_length <= bat.pdu;
    end
    if (rst) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### hw/rtl/isotp_rx_reassembler_core.sv
// iso-tp receive reassembler for classic can frames
// input channel: in_valid / in_stall carrying one request (start, can frame or
// millisecond tick); a request is taken at an edge with in_valid high and in_stall low
// output channel: out_valid / out_stall carrying one result (payload byte, flow
// control request or failure); out_stall from the receiver holds the result in place
// configuration: cfg_write with cfg_index and cfg_data, one register per edge,
// only while no reception results are outstanding
// path: a request is registered, decoded in the next cycle, and its results
// are loaded into the result sequencer, which presents them from its output register
// throughput: one request per cycle while the result stage keeps up; a request
// that yields k results holds the sequencer until all are sent (at most seven:
// flow control plus six bytes, or seven consecutive-frame bytes), so the pace is set
// by the single-result output register; the next request waits in the input register
// a stalled receiver backs the sequencer up and in_stall rises once the input
// register holds a request with results that cannot yet be loaded
// reset: idle phase, no results pending, timeout of 1000 ticks, identifiers zero
module isotp_rx_reassembler_core import isotp_rx_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic [1:0]      cfg_index,
  input  logic [ID_W-1:0] cfg_data,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      func,
  input  logic [ID_W-1:0] frame_id,
  input  logic            frame_ext,
  input  logic [3:0]      frame_len,
  input  logic [7:0]      byte_0,
  input  logic [7:0]      byte_1,
  input  logic [7:0]      byte_2,
  input  logic [7:0]      byte_3,
  input  logic [7:0]      byte_4,
  input  logic [7:0]      byte_5,
  input  logic [7:0]      byte_6,
  input  logic [7:0]      byte_7,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      kind,
  output logic [7:0]      data_byte,
  output logic [11:0]     pdu_length,
  output logic [2:0]      error_code,
  output logic [ID_W-1:0] out_id,
  output logic            out_ext,
  output logic            last
);

  cfg_t   cfg;
  state_t st;
  state_t st_next;
  item_t  s1_item;
  logic   s1_valid;
  logic   s1_go;
  batch_t bat;
  logic   has_res;
  logic   emit_free;
  logic   batch_load;

  always_ff @(posedge clk) begin
    if (cfg_write) begin
      unique case (cfg_index)
        REG_RX_ID:   cfg.rx_id   <= cfg_data;
        REG_TX_ID:   cfg.tx_id   <= cfg_data;
        REG_EXT_IDS: cfg.ext     <= cfg_data[0];
        REG_TIMEOUT: cfg.timeout <= cfg_data[15:0];
      endcase
    end
    if (rst) begin
      cfg.rx_id   <= '0;
      cfg.tx_id   <= '0;
      cfg.ext     <= 1'b0;
      cfg.timeout <= TIMEOUT_RESET;
    end
  end

  // a request with no results never waits for the sequencer
  assign s1_go      = s1_valid && (!has_res || emit_free);
  assign in_stall   = s1_valid && !s1_go;
  assign batch_load = s1_go && has_res;

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_item.func  <= func;
      s1_item.id    <= frame_id;
      s1_item.ext   <= frame_ext;
      s1_item.len   <= frame_len;
      s1_item.bytes <= {byte_7, byte_6, byte_5, byte_4, byte_3, byte_2, byte_1, byte_0};
    end
    if (rst) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      st <= st_next;
    end
    if (rst) begin
      st.phase   <= PHASE_IDLE;
      st.seq     <= 4'd1;
      st.total   <= 12'd0;
      st.rcvd    <= 12'd0;
      st.elapsed <= 16'd0;
    end
  end

  isotp_rx_decode u_decode (
    .item    (s1_item),
    .st      (st),
    .cfg     (cfg),
    .st_next (st_next),
    .bat     (bat),
    .has_res (has_res)
  );

  isotp_rx_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (batch_load),
    .bat_in     (bat),
    .tx_id      (cfg.tx_id),
    .tx_ext     (cfg.ext),
    .out_stall  (out_stall),
    .free       (emit_free),
    .out_valid  (out_valid),
    .kind       (kind),
    .data_byte  (data_byte),
    .pdu_length (pdu_length),
    .error_code (error_code),
    .out_id     (out_id),
    .out_ext    (out_ext),
    .last       (last)
  );

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    batch_load |-> emit_free)
    else $error("result batch loaded while sequencer busy");

  a_fail_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_FAIL) |-> (last && error_code != ERR_NONE))
    else $error("failure result without last or error code");

  a_err_only_fail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_FAIL) |-> (error_code == ERR_NONE))
    else $error("error code on a non-failure result");

  a_start_arms: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_item.func == FUNC_START) |=> (st.phase == PHASE_FIRST && st.rcvd == 12'd0))
    else $error("start request did not arm reception");

endmodule

### tb/sv/isotp_rx_checker.sv
`timescale 1ns / 100ps
module isotp_rx_checker import isotp_rx_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic [1:0]      cfg_index,
  input  logic [ID_W-1:0] cfg_data,
  input  logic            in_valid,
  input  logic            in_stall,
  input  logic [1:0]      func,
  input  logic [ID_W-1:0] frame_id,
  input  logic            frame_ext,
  input  logic [3:0]      frame_len,
  input  logic [7:0]      byte_0,
  input  logic [7:0]      byte_1,
  input  logic [7:0]      byte_2,
  input  logic [7:0]      byte_3,
  input  logic [7:0]      byte_4,
  input  logic [7:0]      byte_5,
  input  logic [7:0]      byte_6,
  input  logic [7:0]      byte_7,
  input  logic            out_valid,
  input  logic            out_stall,
  input  logic [1:0]      kind,
  input  logic [7:0]      data_byte,
  input  logic [11:0]     pdu_length,
  input  logic [2:0]      error_code,
  input  logic [ID_W-1:0] out_id,
  input  logic            out_ext,
  input  logic            last,
  output int unsigned     pending,
  output int unsigned     failures
);

  typedef struct packed {
    logic [1:0]      kind;
    logic [7:0]      data;
    logic [11:0]     pdu;
    logic [2:0]      err;
    logic [ID_W-1:0] id;
    logic            ext;
    logic            last;
  } rx_result_t;

  rx_result_t  awaited_results[$];
  state_t      rx_st;
  cfg_t        rx_cfg;
  int unsigned mismatch_count = 0;

  function automatic string fmt_result(input rx_result_t r);
    return $sformatf("kind=%0d data=%02h pdu=%0d err=%0d id=%07h ext=%0d last=%0d",
                     r.kind, r.data, r.pdu, r.err, r.id, r.ext, r.last);
  endfunction

  task automatic await_result(input logic [1:0] k, input logic [7:0] d,
                              input logic [11:0] pdu, input logic [2:0] e,
                              input logic [ID_W-1:0] id, input logic x, input logic l);
    awaited_results.push_back({k, d, pdu, e, id, x, l});
  endtask

  // any fault ends the reception with a single failure result
  task automatic abort_rx(input logic [2:0] e);
    await_result(KIND_FAIL, 8'h00, rx_st.total, e, '0, 1'b0, 1'b1);
    rx_st.phase = PHASE_IDLE;
  endtask

  task automatic reassemble_request(input item_t q);
    int unsigned flen, dl, tot, remain, take, i;
    logic [3:0]  pci;
    flen = (q.len > 4'd8) ? 8 : {28'd0, q.len};
    pci = q.bytes[0][7:4];
    case (q.func)
      FUNC_START: begin
        rx_st.phase = PHASE_FIRST;
        rx_st.seq = 4'd1;
        rx_st.total = '0;
        rx_st.rcvd = '0;
        rx_st.elapsed = '0;
      end
      FUNC_TICK: begin
        if (rx_st.phase != PHASE_IDLE) begin
          if (rx_st.elapsed != 16'hFFFF) rx_st.elapsed = rx_st.elapsed + 16'd1;
          if (rx_st.elapsed >= rx_cfg.timeout) abort_rx(ERR_TIMEOUT);
        end
      end
      FUNC_FRAME: begin
        if (rx_st.phase != PHASE_IDLE && q.id == rx_cfg.rx_id && q.ext == rx_cfg.ext) begin
          if (flen == 0) begin
            abort_rx(ERR_EMPTY);
          end else if (rx_st.phase == PHASE_FIRST) begin
            if (pci == PCI_SF) begin
              dl = {28'd0, q.bytes[0][3:0]};
              if (dl < 1 || dl > 7) begin
                abort_rx(ERR_SF_LEN);
              end else if (flen < dl + 1) begin
                abort_rx(ERR_TIMEOUT);
              end else begin
                rx_st.total = dl[11:0];
                for (i = 0; i < dl; i++)
                  await_result(KIND_BYTE, q.bytes[1 + i], dl[11:0], ERR_NONE, '0, 1'b0,
                               i + 1 == dl);
                rx_st.rcvd = dl[11:0];
                rx_st.phase = PHASE_IDLE;
              end
            end else if (pci == PCI_FF) begin
              tot = {20'd0, q.bytes[0][3:0], q.bytes[1]};
              if (tot == 0 || flen < 8) begin
                abort_rx(ERR_FF);
              end else begin
                rx_st.total = tot[11:0];
                await_result(KIND_FC, 8'h00, tot[11:0], ERR_NONE, rx_cfg.tx_id, rx_cfg.ext, 1'b0);
                take = (tot < 6) ? tot : 6;
                for (i = 0; i < take; i++)
                  await_result(KIND_BYTE, q.bytes[2 + i], tot[11:0], ERR_NONE, '0, 1'b0,
                               i + 1 == tot);
                rx_st.rcvd = take[11:0];
                rx_st.seq = 4'd1;
                rx_st.elapsed = '0;
                rx_st.phase = (take == tot) ? PHASE_IDLE : PHASE_CONSEC;
              end
            end else begin
              abort_rx(ERR_PCI);
            end
          end else if (rx_st.phase == PHASE_CONSEC) begin
            if (pci != PCI_CF) begin
              abort_rx(ERR_PCI);
            end else if (q.bytes[0][3:0] != rx_st.seq) begin
              abort_rx(ERR_SEQ);
            end else begin
              remain = {20'd0, rx_st.total - rx_st.rcvd};
              take = (remain < 7) ? remain : 7;
              if (flen < take + 1) begin
                abort_rx(ERR_TIMEOUT);
              end else begin
                for (i = 0; i < take; i++)
                  await_result(KIND_BYTE, q.bytes[1 + i], rx_st.total, ERR_NONE, '0, 1'b0,
                               {20'd0, rx_st.rcvd} + i + 1 == {20'd0, rx_st.total});
                rx_st.rcvd = rx_st.rcvd + take[11:0];
                rx_st.seq = rx_st.seq + 4'd1;
                if (rx_st.rcvd >= rx_st.total) rx_st.phase = PHASE_IDLE;
              end
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    rx_result_t seen;
    rx_result_t want;
    if (rst) begin
      rx_st.phase = PHASE_IDLE;
      rx_st.seq = 4'd1;
      rx_st.total = '0;
      rx_st.rcvd = '0;
      rx_st.elapsed = '0;
      rx_cfg.rx_id = '0;
      rx_cfg.tx_id = '0;
      rx_cfg.ext = 1'b0;
      rx_cfg.timeout = TIMEOUT_RESET;
      awaited_results.delete();
    end else begin
      // results leave only after passing the input and output registers, so checking first is safe
      if (out_valid && !out_stall) begin
        seen = {kind, data_byte, pdu_length, error_code, out_id, out_ext, last};
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result: %s", fmt_result(seen));
        end else begin
          want = awaited_results.pop_front();
          if (seen !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result mismatch\n  expected %s\n  actual   %s",
                       fmt_result(want), fmt_result(seen));
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_RX_ID:   rx_cfg.rx_id = cfg_data;
          REG_TX_ID:   rx_cfg.tx_id = cfg_data;
          REG_EXT_IDS: rx_cfg.ext = cfg_data[0];
          REG_TIMEOUT: rx_cfg.timeout = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        reassemble_request({func, frame_id, frame_ext, frame_len,
                            byte_7, byte_6, byte_5, byte_4, byte_3, byte_2, byte_1, byte_0});
    end
    pending <= awaited_results.size();
    failures <= mismatch_count;
  end

endmodule

### tb/sv/tb_isotp_rx_reassembler_core.sv
`timescale 1ns / 100ps
module tb_isotp_rx_reassembler_core import isotp_rx_pkg::*; ();

  localparam int RANDOM_ITEMS = 380;
  localparam int N_SETTINGS = 6;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_write = 1'b0;
  logic [1:0]      cfg_index = REG_RX_ID;
  logic [ID_W-1:0] cfg_data = '0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [1:0]      func = FUNC_TICK;
  logic [ID_W-1:0] frame_id = '0;
  logic            frame_ext = 1'b0;
  logic [3:0]      frame_len = '0;
  logic [7:0]      byte_0 = '0;
  logic [7:0]      byte_1 = '0;
  logic [7:0]      byte_2 = '0;
  logic [7:0]      byte_3 = '0;
  logic [7:0]      byte_4 = '0;
  logic [7:0]      byte_5 = '0;
  logic [7:0]      byte_6 = '0;
  logic [7:0]      byte_7 = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [1:0]      kind;
  logic [7:0]      data_byte;
  logic [11:0]     pdu_length;
  logic [2:0]      error_code;
  logic [ID_W-1:0] out_id;
  logic            out_ext;
  logic            last;
  int unsigned     pending;
  int unsigned     failures;

  logic [ID_W-1:0] cur_rx = '0;
  logic            cur_ext = 1'b0;
  int unsigned     cur_timeout = 1000;
  int unsigned     since_ticks = 0;
  int              counted = 0;
  int              burst_left = 0;
  int              cycle_count = 0;
  int              stall_mode = 0;
  int              mode_left = 0;
  int              stall_phase = 0;

  isotp_rx_reassembler_core u_top (.*);
  isotp_rx_checker u_chk (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver back-pressure, switching between free running, light, heavy and periodic
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(50, 300);
    end
    mode_left--;
    stall_phase++;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= ((stall_phase % 7) < 3);
    endcase
  end

  function automatic logic [7:0][7:0] rand_bytes();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [3:0] full_len();
    return ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) : 4'd8;
  endfunction

  function automatic item_t req_of(input logic [1:0] f, input logic [ID_W-1:0] id,
                                   input logic x, input logic [3:0] len,
                                   input logic [7:0][7:0] b);
    item_t r;
    r.func = f;
    r.id = id;
    r.ext = x;
    r.len = len;
    r.bytes = b;
    return r;
  endfunction

  task automatic send(input item_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    func <= r.func;
    frame_id <= r.id;
    frame_ext <= r.ext;
    frame_len <= r.len;
    byte_0 <= r.bytes[0];
    byte_1 <= r.bytes[1];
    byte_2 <= r.bytes[2];
    byte_3 <= r.bytes[3];
    byte_4 <= r.bytes[4];
    byte_5 <= r.bytes[5];
    byte_6 <= r.bytes[6];
    byte_7 <= r.bytes[7];
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    burst_left--;
    counted++;
  endtask

  task automatic send_frame(input logic [3:0] len, input logic [7:0][7:0] b);
    send(req_of(FUNC_FRAME, cur_rx, cur_ext, len, b));
  endtask

  // start and tick carry random frame fields, which the block must disregard
  task automatic send_ctl(input logic [1:0] f);
    send(req_of(f, ID_W'($urandom), 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                rand_bytes()));
  endtask

  // ticks kept below the timeout so a well-formed message survives
  task automatic add_ticks(input int n);
    for (int k = 0; k < n; k++) begin
      if (since_ticks + 1 < cur_timeout) begin
        send_ctl(FUNC_TICK);
        since_ticks++;
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [ID_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [ID_W-1:0] rx, input logic [ID_W-1:0] tx,
                                input logic x, input logic [15:0] ticks);
    put_reg(REG_RX_ID, rx);
    put_reg(REG_TX_ID, tx);
    put_reg(REG_EXT_IDS, {{(ID_W - 1){1'b0}}, x});
    put_reg(REG_TIMEOUT, {{(ID_W - 16){1'b0}}, ticks});
    cfg_write <= 1'b0;
    cur_rx = rx;
    cur_ext = x;
    cur_timeout = {16'd0, ticks};
  endtask

  task automatic random_message();
    int pick, dl, tot, got, take, seq, n_cf, fault, nib;
    logic [3:0]      len;
    logic [7:0][7:0] b;
    logic            broken;
    if ($urandom_range(0, 19) != 0) send_ctl(FUNC_START);
    since_ticks = 0;
    add_ticks($urandom_range(0, 2));
    if (cur_timeout <= 12 && $urandom_range(0, 7) == 0)
      repeat ((cur_timeout == 0) ? 1 : cur_timeout) send_ctl(FUNC_TICK);
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      dl = $urandom_range(1, 7);
      b = rand_bytes();
      b[0] = {PCI_SF, dl[3:0]};
      len = $urandom_range(0, 1) ? 4'(dl + 1) : full_len();
      send_frame(len, b);
    end else if (pick < 85) begin
      fault = $urandom_range(0, 19);
      tot = (fault == 0) ? $urandom_range(1, 4095) :
            (fault < 4) ? $urandom_range(61, 150) : $urandom_range(1, 60);
      b = rand_bytes();
      b[0] = {PCI_FF, tot[11:8]};
      b[1] = tot[7:0];
      send_frame(full_len(), b);
      since_ticks = 0;
      got = (tot < 6) ? tot : 6;
      seq = 1;
      n_cf = 0;
      broken = 1'b0;
      while (!broken && got < tot && n_cf < 24) begin
        take = (tot - got < 7) ? tot - got : 7;
        b = rand_bytes();
        b[0] = {PCI_CF, seq[3:0]};
        len = ($urandom_range(0, 3) == 0) ? 4'(take + 1) : full_len();
        fault = $urandom_range(0, 59);
        case (fault)
          0: begin
            nib = $urandom_range(0, 14);
            if (nib >= {28'd0, PCI_CF}) nib++;
            b[0][7:4] = nib[3:0];
            broken = 1'b1;
          end
          1: begin
            b[0][3:0] = 4'(seq + $urandom_range(1, 15));
            broken = 1'b1;
          end
          2: begin
            len = 4'($urandom_range(0, take));
            broken = 1'b1;
          end
          3: send(req_of(FUNC_FRAME, cur_rx ^ (29'd1 << $urandom_range(0, ID_W - 1)),
                         cur_ext, full_len(), rand_bytes()));
          4: send(req_of(FUNC_FRAME, cur_rx, !cur_ext, full_len(), rand_bytes()));
          5: add_ticks(1);
          6: begin
            // restart mid-message, the next consecutive frame then has the wrong pci
            send_ctl(FUNC_START);
            broken = 1'b1;
          end
          default: ;
        endcase
        send_frame(len, b);
        got += take;
        seq++;
        n_cf++;
      end
    end else begin
      repeat ($urandom_range(1, 3)) begin
        b = rand_bytes();
        b[0][7:4] = 4'($urandom_range(0, 3));
        send_frame(4'($urandom_range(0, 15)), b);
      end
      if ($urandom_range(0, 3) == 0)
        send(req_of(FUNC_UNUSED, cur_rx, cur_ext, full_len(), rand_bytes()));
    end
    if ($urandom_range(0, 11) == 0) drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero timeout: the first tick of a reception fails it
    apply_settings(29'h12345678, 29'h000007DF, 1'b1, 16'd0);
    send_frame(4'd8, 64'h1122_3344_5566_7701);
    send(req_of(FUNC_UNUSED, cur_rx, cur_ext, 4'd8, rand_bytes()));
    send_ctl(FUNC_START);
    send(req_of(FUNC_FRAME, '0, cur_ext, 4'd8, 64'h1122_3344_5566_7701));
    send(req_of(FUNC_FRAME, cur_rx, !cur_ext, 4'd8, 64'h1122_3344_5566_7701));
    send_frame(4'd15, 64'hFFFF_FFFF_FFFF_FF07);
    send_ctl(FUNC_START);
    send_frame(4'd8, 64'h1122_3344_5566_7700);
    send_ctl(FUNC_START);
    send_frame(4'd8, 64'hA5A5_5A5A_C33C_FF1F);
    send_frame(4'd8, 64'h0102_0304_0506_0721);
    send_frame(4'd8, 64'h0102_0304_0506_0723);
    send_ctl(FUNC_START);
    send_frame(4'd8, 64'h0000_0000_0000_0510);
    send_ctl(FUNC_START);
    send_frame(4'd8, 64'h1111_1111_1111_0010);
    send_ctl(FUNC_START);
    send_frame(4'd0, rand_bytes());
    send_ctl(FUNC_START);
    send_frame(4'd3, 64'h0000_0000_00AA_BB05);
    send_ctl(FUNC_START);
    send_frame(4'd7, 64'h0000_0000_0000_1410);
    send_ctl(FUNC_START);
    send_frame(4'd8, 64'h0000_0000_0000_0030);
    send_ctl(FUNC_START);
    send_frame(4'd8, 64'h0605_0403_0201_0D10);
    send_frame(4'd7, 64'h0E0D_0C0B_0A09_0821);
    send_ctl(FUNC_START);
    send_ctl(FUNC_START);
    send_ctl(FUNC_TICK);

    for (int ph = 0; ph < N_SETTINGS; ph++) begin
      drain();
      case (ph)
        0: apply_settings(29'h1FFFFFFF, '0, 1'b1, 16'hFFFF);
        1: apply_settings('0, 29'h1FFFFFFF, 1'b0, 16'd1);
        2: apply_settings(ID_W'($urandom_range(0, 2047)), ID_W'($urandom_range(0, 2047)),
                          1'b0, 16'($urandom_range(3, 12)));
        default: apply_settings(ID_W'($urandom), ID_W'($urandom), 1'($urandom_range(0, 1)),
                                16'($urandom_range(0, 1) ? $urandom_range(2, 12) :
                                                           $urandom_range(200, 3000)));
      endcase
      while (counted < (ph + 1) * RANDOM_ITEMS / N_SETTINGS) random_message();
    end
    drain();

    if (failures == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
